// File: hw/rtl/mefb_pkg.sv
// Package for the motor encoder feedback tracker: field widths, the item
// record passed from front to back, register codes and divider constants.
// No dependencies.
`default_nettype none

package mefb_pkg;

	// field widths
	localparam int SLOT_W    = 4;
	localparam int POS_W     = 13;
	localparam int SPEED_W   = 16;
	localparam int CUR_W     = 16;
	localparam int MAG_W     = 15;
	localparam int DELTA_W   = 14;
	localparam int TURN_W    = 16;
	localparam int TOTAL_W   = 30;
	localparam int CNT_W     = 8;
	localparam int MASK_W    = 16;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 16;

	// slots addressable by the slot field
	localparam int SLOT_SPACE    = 1 << SLOT_W;
	localparam int NUM_SLOTS_DEF = 16;

	// encoder resolution (power of two, matches POS_W)
	localparam int COUNTS_PER_TURN = 8192;
	localparam int HALF_TURN       = COUNTS_PER_TURN / 2;

	// configuration reset values
	localparam logic [CNT_W-1:0]  CAPTURE_LENGTH_RST = 8'd51;
	localparam logic [MASK_W-1:0] CAPTURE_MASK_RST   = 16'h000F;
	localparam logic [CNT_W-1:0]  CNT_MAX            = '1;

	// current filter: floor(x / 10) as (x * 419431) >> 22, exact for x < 699050
	localparam int SUM_W         = 19;
	localparam int DIV10_MULT_W  = 19;
	localparam logic [DIV10_MULT_W-1:0] DIV10_MULT = 19'd419431;
	localparam int DIV10_SHIFT   = 22;

	// front-to-back queue
	localparam int QUEUE_DEPTH = 2;

	// configuration register codes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CAPTURE_LENGTH,
		CFG_CAPTURE_MASK
	} cfg_reg_t;

	// classified frame as held in the queue
	typedef struct packed {
		logic [SLOT_W-1:0]         slot;
		logic                      masked;
		logic [POS_W-1:0]          position;
		logic signed [SPEED_W-1:0] speed;
		logic [MAG_W-1:0]          mag;
	} mefb_item_t;

	// queue fill status
	typedef struct packed {
		logic full;
		logic empty;
	} mefb_q_stat_t;

endpackage

`default_nettype wire

// File: hw/rtl/mefb_front.sv
// Front stage: accepts frames, drops out-of-range slots, reduces the
// position, takes the current magnitude and the capture mask bit. Uses mefb_pkg.
`default_nettype none

module mefb_front import mefb_pkg::*; #(
	parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic [SLOT_W-1:0]         slot,
	input  wire logic [POS_W-1:0]          position_raw,
	input  wire logic signed [SPEED_W-1:0] speed_raw,
	input  wire logic signed [CUR_W-1:0]   current_raw,
	input  wire logic [MASK_W-1:0]         capture_slot_mask,
	output logic                           push_valid,
	input  wire logic                      push_ready,
	output mefb_item_t                     push_item
);

	logic       valid_s1;
	mefb_item_t item_s1;
	mefb_item_t item_c;
	logic       slot_ok;

	// classification
	always_comb begin
		slot_ok         = 32'(slot) < NUM_SLOTS;
		item_c.slot     = slot;
		item_c.masked   = capture_slot_mask[slot];
		item_c.position = POS_W'(position_raw % COUNTS_PER_TURN);
		item_c.speed    = speed_raw;
		if (current_raw == {1'b1, {(CUR_W-1){1'b0}}}) begin
			item_c.mag = '1;
		end else if (current_raw < 0) begin
			item_c.mag = MAG_W'(-current_raw);
		end else begin
			item_c.mag = MAG_W'(current_raw);
		end
	end

	// stage accepts when empty or when its item moves into the queue
	assign in_ready   = !valid_s1 || push_ready;
	assign push_valid = valid_s1;
	assign push_item  = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid && slot_ok;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= item_c;
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/mefb_queue.sv
// Short FIFO between front and back so each side stalls on its own.
// Uses mefb_pkg for the item record and status struct.
`default_nettype none

module mefb_queue import mefb_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   push_valid,
	output logic        push_ready,
	input  mefb_item_t  push_item,
	output logic        pop_valid,
	input  wire logic   pop_ready,
	output mefb_item_t  pop_item,
	output mefb_q_stat_t stat
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_QW = $clog2(DEPTH + 1);

	mefb_item_t         mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_QW-1:0]  count_q;
	logic               do_push;
	logic               do_pop;

	assign stat.full  = count_q == CNT_QW'(DEPTH);
	assign stat.empty = count_q == '0;
	assign push_ready = !stat.full;
	assign pop_valid  = !stat.empty;
	assign pop_item   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/mefb_back.sv
// Back stage: per-slot state read-modify-write (capture, unwrap, turn count,
// current filter) and the output register. Uses mefb_pkg.
`default_nettype none

module mefb_back import mefb_pkg::*; #(
	parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      q_valid,
	output logic                           q_pop,
	input  mefb_item_t                     q_item,
	input  wire logic [CNT_W-1:0]          capture_length,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic [SLOT_W-1:0]              slot_out,
	output logic                           capturing,
	output logic signed [DELTA_W-1:0]      position_delta,
	output logic signed [TURN_W-1:0]       turn_count,
	output logic signed [TOTAL_W-1:0]      total_position,
	output logic signed [SPEED_W-1:0]      speed_out,
	output logic [MAG_W-1:0]               current_filtered
);

	localparam int DEPTH = (NUM_SLOTS < SLOT_SPACE) ? NUM_SLOTS : SLOT_SPACE;
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int DIFF_W = POS_W + 2;
	localparam int PROD_W = SUM_W + DIV10_MULT_W;
	localparam logic signed [DIFF_W-1:0] HALF_P = DIFF_W'(HALF_TURN);
	localparam logic signed [DIFF_W-1:0] HALF_N = -DIFF_W'(HALF_TURN);
	localparam logic signed [DIFF_W-1:0] TURN_D = DIFF_W'(COUNTS_PER_TURN);
	localparam logic signed [TURN_W-1:0] TURN_MIN = {1'b1, {(TURN_W-1){1'b0}}};
	localparam logic signed [TURN_W-1:0] TURN_MAX = {1'b0, {(TURN_W-1){1'b1}}};

	// per-slot state
	logic [POS_W-1:0]         last_pos_q [DEPTH];
	logic [POS_W-1:0]         offset_q   [DEPTH];
	logic signed [TURN_W-1:0] turns_q    [DEPTH];
	logic [CNT_W-1:0]         fcount_q   [DEPTH];
	logic [MAG_W-1:0]         prev_q     [DEPTH];
	logic [MAG_W-1:0]         prev2_q    [DEPTH];

	logic                      out_valid_q;
	logic [IDX_W-1:0]          idx;
	logic                      capture;
	logic signed [DIFF_W-1:0]  diff;
	logic signed [DIFF_W-1:0]  delta;
	logic signed [TURN_W-1:0]  turns_cur;
	logic signed [TURN_W-1:0]  turns_n;
	logic [POS_W-1:0]          offset_eff;
	logic signed [TOTAL_W-1:0] total;
	logic [SUM_W-1:0]          sum;
	logic [PROD_W-1:0]         prod;
	logic [MAG_W-1:0]          filt;

	assign idx   = q_item.slot[IDX_W-1:0];
	assign q_pop = q_valid && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;

	// capture decision and unwrap
	always_comb begin
		capture   = q_item.masked && (fcount_q[idx] < capture_length);
		turns_cur = turns_q[idx];
		diff      = $signed({2'b00, q_item.position}) - $signed({2'b00, last_pos_q[idx]});
		turns_n   = turns_cur;
		if (diff > HALF_P) begin
			delta = diff - TURN_D;
			if (turns_cur != TURN_MIN) begin
				turns_n = turns_cur - 1'b1;
			end
		end else if (diff < HALF_N) begin
			delta = diff + TURN_D;
			if (turns_cur != TURN_MAX) begin
				turns_n = turns_cur + 1'b1;
			end
		end else begin
			delta = diff;
		end
		if (capture) begin
			delta   = '0;
			turns_n = turns_cur;
		end
		offset_eff = capture ? q_item.position : offset_q[idx];
		total = (TOTAL_W'(turns_n) <<< POS_W) + TOTAL_W'(q_item.position)
			- TOTAL_W'(offset_eff);
	end

	// current filter: (mag + prev + 8*prev2) / 10 by reciprocal multiply
	always_comb begin
		sum  = SUM_W'(q_item.mag) + SUM_W'(prev_q[idx]) + (SUM_W'(prev2_q[idx]) << 3);
		prod = PROD_W'(sum) * PROD_W'(DIV10_MULT);
		filt = capture ? prev_q[idx] : MAG_W'(prod >> DIV10_SHIFT);
	end

	// state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) begin
				last_pos_q[i] <= '0;
				offset_q[i]   <= '0;
				turns_q[i]    <= '0;
				fcount_q[i]   <= '0;
				prev_q[i]     <= '0;
				prev2_q[i]    <= '0;
			end
		end else if (q_pop) begin
			if (fcount_q[idx] != CNT_MAX) begin
				fcount_q[idx] <= fcount_q[idx] + 1'b1;
			end
			last_pos_q[idx] <= q_item.position;
			if (capture) begin
				offset_q[idx] <= q_item.position;
			end else begin
				turns_q[idx] <= turns_n;
				prev2_q[idx] <= prev_q[idx];
				prev_q[idx]  <= filt;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (q_pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			slot_out         <= q_item.slot;
			capturing        <= capture;
			position_delta   <= DELTA_W'(delta);
			turn_count       <= turns_n;
			total_position   <= total;
			speed_out        <= q_item.speed;
			current_filtered <= filt;
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/motor_encoder_feedback_tracker_unit.sv
// Top level of the motor encoder feedback tracker: configuration registers,
// front stage, queue and back stage. Uses mefb_pkg, mefb_front, mefb_queue, mefb_back.
//
//   channel   signals                                        direction
//   input     in_valid/in_ready, slot, position_raw,          in
//             speed_raw, current_raw
//   result    out_valid/out_ready, slot_out, capturing, ...   out
//   config    cfg_we, cfg_index, cfg_data                     in (write only)
//
// One frame per cycle sustained while out_ready is high; a result passes
// through the front register, the queue and the back output register after
// its input transfer.
// Per-slot state sits in flip-flops read and written in the back stage in
// the same cycle, so back-to-back frames of one slot need no wait.
// Reset clears all slot state and loads the register defaults at once.
// A stalled result fills the queue before the input side stops.
`default_nettype none

module motor_encoder_feedback_tracker_unit import mefb_pkg::*; #(
	parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_we,
	input  wire logic [CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [CFG_DATA_W-1:0]     cfg_data,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic [SLOT_W-1:0]         slot,
	input  wire logic [POS_W-1:0]          position_raw,
	input  wire logic signed [SPEED_W-1:0] speed_raw,
	input  wire logic signed [CUR_W-1:0]   current_raw,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic [SLOT_W-1:0]              slot_out,
	output logic                           capturing,
	output logic signed [DELTA_W-1:0]      position_delta,
	output logic signed [TURN_W-1:0]       turn_count,
	output logic signed [TOTAL_W-1:0]      total_position,
	output logic signed [SPEED_W-1:0]      speed_out,
	output logic [MAG_W-1:0]               current_filtered
);

	logic [CNT_W-1:0]  capture_length_q;
	logic [MASK_W-1:0] capture_slot_mask_q;
	logic              push_valid;
	logic              push_ready;
	mefb_item_t        push_item;
	logic              q_valid;
	logic              q_pop;
	mefb_item_t        q_item;
	mefb_q_stat_t      q_stat;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capture_length_q    <= CAPTURE_LENGTH_RST;
			capture_slot_mask_q <= CAPTURE_MASK_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				CFG_CAPTURE_LENGTH: capture_length_q    <= cfg_data[CNT_W-1:0];
				CFG_CAPTURE_MASK:   capture_slot_mask_q <= cfg_data[MASK_W-1:0];
				default: ;
			endcase
		end
	end

	mefb_front #(.NUM_SLOTS(NUM_SLOTS)) u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.slot             (slot),
		.position_raw     (position_raw),
		.speed_raw        (speed_raw),
		.current_raw      (current_raw),
		.capture_slot_mask(capture_slot_mask_q),
		.push_valid       (push_valid),
		.push_ready       (push_ready),
		.push_item        (push_item)
	);

	mefb_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_item (push_item),
		.pop_valid (q_valid),
		.pop_ready (q_pop),
		.pop_item  (q_item),
		.stat      (q_stat)
	);

	mefb_back #(.NUM_SLOTS(NUM_SLOTS)) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_valid         (q_valid),
		.q_pop           (q_pop),
		.q_item          (q_item),
		.capture_length  (capture_length_q),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.slot_out        (slot_out),
		.capturing       (capturing),
		.position_delta  (position_delta),
		.turn_count      (turn_count),
		.total_position  (total_position),
		.speed_out       (speed_out),
		.current_filtered(current_filtered)
	);

`ifndef SYNTHESIS
	// a capture frame reports no movement
	a_capture_no_delta: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && capturing |-> position_delta == '0)
		else $error("capture result with nonzero delta");

	// capture only happens in slots enabled by the mask
	a_capture_masked: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && capturing |-> capture_slot_mask_q[slot_out])
		else $error("capture in unmasked slot");

	// queue status is consistent
	a_queue_stat: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_stat.full && q_stat.empty))
		else $error("queue both full and empty");

	// back pulls from the queue only when it holds an item
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_stat.empty)
		else $error("queue pop while empty");
`endif

endmodule

`default_nettype wire
